@@ src/gpad_pkg.sv @@
// ----------------------------------------------------------------------------
// gpad_pkg: shared types, constants and scaling functions
// Report and result layouts, register map and the per-axis conditioning math
// used by the gamepad conditioner.
// ----------------------------------------------------------------------------
`default_nettype none

package gpad_pkg;

    // Scaling constants
    localparam int unsigned TRIG_DIV   = 1023;
    localparam int unsigned STICK_DIV  = 511;
    localparam int unsigned PCT_FULL   = 100;
    localparam int          PCT_MIN    = -100;

    // Field widths
    localparam int unsigned RAW_W      = 10;
    localparam int unsigned BTN_W      = 4;
    localparam int unsigned TRIG_PCT_W = 7;
    localparam int unsigned STICK_PCT_W = 8;
    localparam int unsigned EDGE_W     = 8;

    // Stream widths (fields packed low to high, padded to bytes)
    localparam int unsigned S_TDATA_W  = 72;
    localparam int unsigned S_TUSER_W  = 1;
    localparam int unsigned M_TDATA_W  = 56;

    // Configuration port
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 32;
    localparam logic [RAW_W-1:0] TRIG_DZ_RESET  = 10'd20;
    localparam logic [RAW_W-1:0] STICK_DZ_RESET = 10'd20;

    // Register indexes (address bit 2 selects the register)
    localparam logic REG_TRIG_DZ  = 1'b0;
    localparam logic REG_STICK_DZ = 1'b1;

    typedef struct packed {
        logic                    link_up;
        logic [RAW_W-1:0]        raw_left_trigger;
        logic [RAW_W-1:0]        raw_right_trigger;
        logic signed [RAW_W-1:0] raw_left_x;
        logic signed [RAW_W-1:0] raw_left_y;
        logic signed [RAW_W-1:0] raw_right_x;
        logic signed [RAW_W-1:0] raw_right_y;
        logic [BTN_W-1:0]        dpad_bits;
        logic [BTN_W-1:0]        face_bits;
    } report_t;

    typedef struct packed {
        logic [TRIG_PCT_W-1:0]         left_trigger_pct;
        logic [TRIG_PCT_W-1:0]         right_trigger_pct;
        logic signed [STICK_PCT_W-1:0] left_x_pct;
        logic signed [STICK_PCT_W-1:0] left_y_pct;
        logic signed [STICK_PCT_W-1:0] right_x_pct;
        logic signed [STICK_PCT_W-1:0] right_y_pct;
        logic [EDGE_W-1:0]             press_edges;
    } result_t;

    typedef struct packed {
        logic [RAW_W-1:0] trig_threshold;
        logic [RAW_W-1:0] stick_deadzone;
    } cfg_t;

    // Trigger: zero below deadzone, else raw*100/1023.
    // Quotient estimate is prod>>10; it is low by at most one, fix with one compare.
    function automatic logic [TRIG_PCT_W-1:0] trigger_pct(
        input logic [RAW_W-1:0] raw,
        input logic [RAW_W-1:0] dz
    );
        logic [16:0]           prod;
        logic [TRIG_PCT_W-1:0] q0;
        logic [16:0]           rem;
        logic [TRIG_PCT_W-1:0] q;
        prod = 17'(raw) * 17'(PCT_FULL);
        q0   = prod[16:10];
        rem  = prod - {q0, 10'b0} + 17'(q0);
        q    = q0 + TRIG_PCT_W'(rem >= 17'(TRIG_DIV));
        if (raw < dz) begin
            q = '0;
        end
        return q;
    endfunction

    // Stick: zero when magnitude below deadzone, else raw*100/511 toward zero,
    // clamped to +/-100. Work on magnitude and reapply the sign.
    function automatic logic signed [STICK_PCT_W-1:0] stick_pct(
        input logic signed [RAW_W-1:0] raw,
        input logic [RAW_W-1:0]        dz
    );
        logic                    neg;
        logic [RAW_W-1:0]        mag;
        logic [15:0]             prod;
        logic [TRIG_PCT_W-1:0]   q0;
        logic [15:0]             rem;
        logic [TRIG_PCT_W-1:0]   q;
        logic [STICK_PCT_W-1:0]  mag_pct;
        logic [STICK_PCT_W-1:0]  res;
        neg  = raw[RAW_W-1];
        mag  = neg ? (~raw + 1'b1) : raw;
        prod = 16'(mag) * 16'(PCT_FULL);
        q0   = prod[15:9];
        rem  = prod - {q0, 9'b0} + 16'(q0);
        q    = q0 + TRIG_PCT_W'(rem >= 16'(STICK_DIV));
        if (q > TRIG_PCT_W'(PCT_FULL)) begin
            q = TRIG_PCT_W'(PCT_FULL);
        end
        mag_pct = {1'b0, q};
        res     = neg ? (~mag_pct + 1'b1) : mag_pct;
        if (mag < dz) begin
            res = '0;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

@@ src/gpad_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// gpad_cfg_regs: APB configuration registers
// Holds the trigger and stick deadzones; writes land on the access cycle,
// reads return the stored value.
// ----------------------------------------------------------------------------
`default_nettype none

module gpad_cfg_regs (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [gpad_pkg::CFG_ADDR_W-1:0]   paddr,
    input  wire logic [gpad_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic      [gpad_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                                   pready,
    output gpad_pkg::cfg_t                         cfg
);
    import gpad_pkg::*;

    logic [RAW_W-1:0] trig_dz_reg;
    logic [RAW_W-1:0] stick_dz_reg;
    logic             reg_idx;
    logic             wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign wr_en   = psel & penable & pwrite & pready;

    // Write the selected deadzone
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trig_dz_reg  <= TRIG_DZ_RESET;
            stick_dz_reg <= STICK_DZ_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                REG_TRIG_DZ:  trig_dz_reg  <= pwdata[RAW_W-1:0];
                REG_STICK_DZ: stick_dz_reg <= pwdata[RAW_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        case (reg_idx)
            REG_TRIG_DZ:  prdata = CFG_DATA_W'(trig_dz_reg);
            REG_STICK_DZ: prdata = CFG_DATA_W'(stick_dz_reg);
            default:      prdata = '0;
        endcase
    end

    assign cfg.trig_threshold = trig_dz_reg;
    assign cfg.stick_deadzone = stick_dz_reg;

endmodule

`default_nettype wire

@@ src/gpad_in_stage.sv @@
// ----------------------------------------------------------------------------
// gpad_in_stage: input register
// Captures one report beat per cycle and unpacks it for the conditioning
// stage; refills in the same cycle the held beat moves on.
// ----------------------------------------------------------------------------
`default_nettype none

module gpad_in_stage (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [gpad_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    input  wire logic [gpad_pkg::S_TUSER_W-1:0]    s_axis_tuser,
    output logic                                   rpt_valid,
    input  wire logic                              rpt_ready,
    output gpad_pkg::report_t                      rpt
);
    import gpad_pkg::*;

    logic    valid_reg;
    report_t rpt_reg;
    report_t rpt_next;

    assign s_axis_tready = !valid_reg || rpt_ready;

    // Unpack the beat
    always_comb begin
        rpt_next.link_up           = s_axis_tuser[0];
        rpt_next.raw_left_trigger  = s_axis_tdata[9:0];
        rpt_next.raw_right_trigger = s_axis_tdata[19:10];
        rpt_next.raw_left_x        = s_axis_tdata[29:20];
        rpt_next.raw_left_y        = s_axis_tdata[39:30];
        rpt_next.raw_right_x       = s_axis_tdata[49:40];
        rpt_next.raw_right_y       = s_axis_tdata[59:50];
        rpt_next.dpad_bits         = s_axis_tdata[63:60];
        rpt_next.face_bits         = s_axis_tdata[67:64];
    end

    // Hold valid until the next stage takes the beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            valid_reg <= s_axis_tvalid;
        end
    end

    // Load payload on accept
    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            rpt_reg <= rpt_next;
        end
    end

    assign rpt_valid = valid_reg;
    assign rpt       = rpt_reg;

endmodule

`default_nettype wire

@@ src/gpad_cond_stage.sv @@
// ----------------------------------------------------------------------------
// gpad_cond_stage: conditioning and result register
// Applies deadzones and percent scaling, finds button press edges against
// the previous report (history cleared by a link-down report), and holds
// the result until it is taken.
`default_nettype none

module gpad_cond_stage (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire gpad_pkg::cfg_t        cfg,
    input  wire logic                  rpt_valid,
    output logic                       rpt_ready,
    input  wire gpad_pkg::report_t     rpt,
    output logic                       res_valid,
    input  wire logic                  res_ready,
    output gpad_pkg::result_t          res
);
    import gpad_pkg::*;

    logic             valid_reg;
    result_t          res_reg;
    result_t          res_next;
    logic [BTN_W-1:0] prev_dpad_reg;
    logic [BTN_W-1:0] prev_face_reg;
    logic             take;

    assign rpt_ready = !valid_reg || res_ready;
    assign take      = rpt_valid && rpt_ready;

    // Scale axes and detect press edges; link down forces all zero
    always_comb begin
        res_next.left_trigger_pct  = trigger_pct(rpt.raw_left_trigger, cfg.trig_threshold);
        res_next.right_trigger_pct = trigger_pct(rpt.raw_right_trigger, cfg.trig_threshold);
        res_next.left_x_pct        = stick_pct(rpt.raw_left_x, cfg.stick_deadzone);
        res_next.left_y_pct        = stick_pct(rpt.raw_left_y, cfg.stick_deadzone);
        res_next.right_x_pct       = stick_pct(rpt.raw_right_x, cfg.stick_deadzone);
        res_next.right_y_pct       = stick_pct(rpt.raw_right_y, cfg.stick_deadzone);
        res_next.press_edges       = {rpt.face_bits & ~prev_face_reg,
                                      rpt.dpad_bits & ~prev_dpad_reg};
        if (!rpt.link_up) begin
            res_next = '0;
        end
    end

    // Advance button history on each consumed report; clear it on link down
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_dpad_reg <= '0;
            prev_face_reg <= '0;
        end else if (take) begin
            prev_dpad_reg <= rpt.link_up ? rpt.dpad_bits : '0;
            prev_face_reg <= rpt.link_up ? rpt.face_bits : '0;
        end
    end

    // Hold result valid until the downstream takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (rpt_ready) begin
            valid_reg <= rpt_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            res_reg <= res_next;
        end
    end

    assign res_valid = valid_reg;
    assign res       = res_reg;

`ifndef SYNTHESIS
    // Link down gives an all-zero result
    assert property (@(posedge aclk) disable iff (!aresetn)
        (take && !rpt.link_up) |=> (res_reg == '0))
        else $error("link-down report did not give a zero result");

    // Link down clears the button history
    assert property (@(posedge aclk) disable iff (!aresetn)
        (take && !rpt.link_up) |=> (prev_dpad_reg == '0 && prev_face_reg == '0))
        else $error("button history not cleared on link down");

    // A d-pad edge is only reported for a button pressed in that report
    assert property (@(posedge aclk) disable iff (!aresetn)
        take |=> ((res_reg.press_edges[BTN_W-1:0] & ~$past(rpt.dpad_bits)) == '0))
        else $error("d-pad edge reported for a released button");

    // Trigger, left X and right Y percentages stay within range
    assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> (res_reg.left_trigger_pct <= TRIG_PCT_W'(PCT_FULL) &&
                       res_reg.right_trigger_pct <= TRIG_PCT_W'(PCT_FULL) &&
                       res_reg.left_x_pct >= -8'sd100 && res_reg.left_x_pct <= 8'sd100 &&
                       res_reg.right_y_pct >= -8'sd100 && res_reg.right_y_pct <= 8'sd100))
        else $error("scaled value out of range");
`endif

endmodule

`default_nettype wire

@@ src/gamepad_axis_deadzone_and_button_edges.sv @@
// ----------------------------------------------------------------------------
// gamepad_axis_deadzone_and_button_edges: controller report conditioner
// An accepted input beat passes the input register, then the result register, to m_axis.
// Throughput: one report per cycle; input register and result register each
//   refill in the cycle their beat moves on, so stalls only back up the pipe.
// Reset (aresetn low, synchronous): pipeline empties, button history clears,
//   both deadzones return to 20.
// ----------------------------------------------------------------------------
`default_nettype none

module gamepad_axis_deadzone_and_button_edges (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // Input reports
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // tdata, low to high: raw_left_trigger[9:0], raw_right_trigger[19:10],
    // raw_left_x[29:20], raw_left_y[39:30], raw_right_x[49:40],
    // raw_right_y[59:50], dpad_bits[63:60], face_bits[67:64], zero pad
    input  wire logic [gpad_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // tuser: link_up[0]
    input  wire logic [gpad_pkg::S_TUSER_W-1:0]    s_axis_tuser,
    // Results
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // tdata, low to high: left_trigger_pct[6:0], right_trigger_pct[13:7],
    // left_x_pct[21:14], left_y_pct[29:22], right_x_pct[37:30],
    // right_y_pct[45:38], press_edges[53:46], zero pad
    output logic [gpad_pkg::M_TDATA_W-1:0]         m_axis_tdata,
    // Configuration
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [gpad_pkg::CFG_ADDR_W-1:0]   paddr,
    input  wire logic [gpad_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic      [gpad_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                                   pready
);
    import gpad_pkg::*;

    cfg_t    cfg;
    report_t rpt;
    logic    rpt_valid;
    logic    rpt_ready;
    result_t res;

    gpad_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    gpad_in_stage u_in (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .rpt_valid     (rpt_valid),
        .rpt_ready     (rpt_ready),
        .rpt           (rpt)
    );

    gpad_cond_stage u_cond (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .rpt_valid (rpt_valid),
        .rpt_ready (rpt_ready),
        .rpt       (rpt),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res       (res)
    );

    // Pack the result beat
    assign m_axis_tdata = {2'b00,
                           res.press_edges,
                           res.right_y_pct,
                           res.right_x_pct,
                           res.left_y_pct,
                           res.left_x_pct,
                           res.right_trigger_pct,
                           res.left_trigger_pct};

endmodule

`default_nettype wire

@@ dv/tb_gamepad_axis_deadzone_and_button_edges.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_gamepad_axis_deadzone_and_button_edges: report conditioner testbench
// Streams controller reports into the conditioner and checks every result
// beat against a local model of the trigger/stick scaling and button edge
// detection. A short table covers extremes, link loss and deadzone corners,
// then random reports run under several deadzone settings and idle patterns.
// ----------------------------------------------------------------------------

module tb_gamepad_axis_deadzone_and_button_edges;

    import gpad_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int PHASE_COUNT     = 8;
    localparam int REPORTS_PER_PHASE = 206;
    localparam int DRAIN_CYCLES    = 6;
    localparam int MAX_REPORTED    = 10;

    // Idle patterns
    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    // One directed row: the report and, where obvious, the result it must give
    typedef struct packed {
        report_t rpt;
        logic    typed;
        result_t res;
    } dir_step_t;

    localparam dir_step_t DIR_STEPS [12] = '{
        '{'{1, 0, 1023, 511, -512, 0, -1, 4'hF, 4'hF}, 1'b1,
          '{0, 100, 100, -100, 0, 0, 8'hFF}},
        '{'{1, 1023, 0, -512, 511, -511, 511, 4'hF, 4'hF}, 1'b1,
          '{100, 0, -100, 100, -100, 100, 8'h00}},
        '{'{0, 1023, 1023, -512, 511, 511, -512, 4'hF, 4'hF}, 1'b1, '0},
        '{'{1, 19, 20, 19, -19, 20, -20, 4'hF, 4'hF}, 1'b1,
          '{0, 1, 0, 0, 3, -3, 8'hFF}},
        '{'{1, 10'h155, 10'h2AA, 10'h155, 10'h2AA, 10'h2AA, 10'h155, 4'h0, 4'h0},
          1'b0, '0},
        '{'{1, 10'h2AA, 10'h155, 10'h2AA, 10'h155, 10'h155, 10'h2AA, 4'h5, 4'hA},
          1'b0, '0},
        '{'{1, 1022, 1, 510, -510, 1, -2, 4'hA, 4'h5}, 1'b0, '0},
        '{'{1, 512, 511, 256, -256, -1, 2, 4'h0, 4'h0}, 1'b0, '0},
        '{'{0, 0, 0, 0, 0, 0, 0, 4'h0, 4'h0}, 1'b1, '0},
        '{'{1, 1, 1022, -21, 21, -511, 510, 4'h1, 4'h1}, 1'b0, '0},
        '{'{1, 21, 19, 0, -20, 511, -512, 4'h3, 4'h3}, 1'b0, '0},
        '{'{1, 1023, 1023, 511, 511, -512, -512, 4'h0, 4'h8}, 1'b0, '0}
    };

    logic                  aclk;
    logic                  aresetn;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata;   // trig L, trig R, LX, LY, RX, RY, dpad, face, pad
    logic [S_TUSER_W-1:0]  s_axis_tuser;   // link_up
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [M_TDATA_W-1:0]  m_axis_tdata;   // trig L, trig R, LX, LY, RX, RY, edges, pad
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // Model state
    int unsigned trig_dz;
    int unsigned stick_dz;
    logic [BTN_W-1:0] held_dpad;
    logic [BTN_W-1:0] held_face;

    result_t    pending_results [$];
    int         error_count;
    int         cycle_count;
    idle_mode_t idle_mode;

    gamepad_axis_deadzone_and_button_edges i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // 10 ns clock
    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // Trigger: zero under the deadzone, else truncated percentage
    function automatic logic [TRIG_PCT_W-1:0] scale_trigger(logic [RAW_W-1:0] raw);
        int unsigned v = raw;
        if (v < trig_dz) begin
            return '0;
        end
        return TRIG_PCT_W'(v * 100 / 1023);
    endfunction

    // Stick: zero under the deadzone, else signed percentage toward zero, clamped
    function automatic logic signed [STICK_PCT_W-1:0] scale_stick(
        logic signed [RAW_W-1:0] raw
    );
        int v = raw;
        int mag;
        int pct;
        mag = (v < 0) ? -v : v;
        if (longint'(mag) < longint'(stick_dz)) begin
            return '0;
        end
        pct = v * 100 / 511;
        if (pct > 100) begin
            pct = 100;
        end
        if (pct < -100) begin
            pct = -100;
        end
        return STICK_PCT_W'(pct);
    endfunction

    // Condition one report and advance the button history
    function automatic result_t condition_report(report_t r);
        result_t res;
        res = '0;
        if (!r.link_up) begin
            held_dpad = '0;
            held_face = '0;
            return res;
        end
        res.left_trigger_pct  = scale_trigger(r.raw_left_trigger);
        res.right_trigger_pct = scale_trigger(r.raw_right_trigger);
        res.left_x_pct        = scale_stick(r.raw_left_x);
        res.left_y_pct        = scale_stick(r.raw_left_y);
        res.right_x_pct       = scale_stick(r.raw_right_x);
        res.right_y_pct       = scale_stick(r.raw_right_y);
        res.press_edges       = {r.face_bits & ~held_face, r.dpad_bits & ~held_dpad};
        held_dpad = r.dpad_bits;
        held_face = r.face_bits;
        return res;
    endfunction

    function automatic void note_error(string msg);
        if (error_count < MAX_REPORTED) begin
            $display("ERROR @%0t: %s", $realtime, msg);
        end
        error_count++;
    endfunction

    function automatic void compare_field(string fname, int want, int got);
        if (want != got) begin
            note_error($sformatf("%s expected %0d got %0d", fname, want, got));
        end
    endfunction

    // Random raw values, biased toward the deadzone edges and the rails
    function automatic logic [RAW_W-1:0] pick_trigger();
        int v;
        case ($urandom_range(0, 3))
            0: v = $urandom_range(0, 1023);
            1: begin
                case ($urandom_range(0, 3))
                    0: v = 0;
                    1: v = 1;
                    2: v = 1022;
                    default: v = 1023;
                endcase
            end
            default: v = int'(trig_dz) + $urandom_range(0, 2) - 1;
        endcase
        if (v < 0) begin
            v = 0;
        end
        if (v > 1023) begin
            v = 1023;
        end
        return RAW_W'(v);
    endfunction

    function automatic logic signed [RAW_W-1:0] pick_stick();
        int m;
        logic neg;
        neg = 1'($urandom);
        case ($urandom_range(0, 3))
            0: return RAW_W'($urandom);
            1: begin
                case ($urandom_range(0, 3))
                    0: m = 0;
                    1: m = 1;
                    2: m = 511;
                    default: m = 512;
                endcase
            end
            default: m = int'(stick_dz > 512 ? 512 : stick_dz) + $urandom_range(0, 2) - 1;
        endcase
        if (m < 0) begin
            m = 0;
        end
        if (!neg && m > 511) begin
            m = 511;
        end
        if (m > 512) begin
            m = 512;
        end
        return neg ? RAW_W'(-m) : RAW_W'(m);
    endfunction

    function automatic report_t random_report();
        report_t r;
        r.link_up           = ($urandom_range(0, 99) < 90);
        r.raw_left_trigger  = pick_trigger();
        r.raw_right_trigger = pick_trigger();
        r.raw_left_x        = pick_stick();
        r.raw_left_y        = pick_stick();
        r.raw_right_x       = pick_stick();
        r.raw_right_y       = pick_stick();
        r.dpad_bits         = ($urandom_range(0, 3) == 0) ? held_dpad : BTN_W'($urandom);
        r.face_bits         = ($urandom_range(0, 3) == 0) ? held_face : BTN_W'($urandom);
        return r;
    endfunction

    // Send one report beat and queue what it must produce
    task automatic send_report(report_t r, logic typed, result_t typed_res);
        int idle_pct;
        result_t predicted;
        idle_pct = (idle_mode == IDLE_SENDER) ? 47 : (idle_mode == IDLE_BOTH) ? 27 : 0;
        while ($urandom_range(0, 99) < idle_pct) begin
            @(negedge aclk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= r.link_up;
        s_axis_tdata  <= {4'b0, r.face_bits, r.dpad_bits, r.raw_right_y, r.raw_right_x,
                          r.raw_left_y, r.raw_left_x, r.raw_right_trigger,
                          r.raw_left_trigger};
        @(posedge aclk);
        while (!s_axis_tready) begin
            @(posedge aclk);
        end
        predicted = condition_report(r);
        pending_results.push_back(typed ? typed_res : predicted);
    endtask

    // Drop valid and hold until every queued result has come back
    task automatic drain();
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // Register write: setup beat, then access beat until pready
    task automatic write_reg(logic reg_idx, int unsigned value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= {22'($urandom), 10'(value)};
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) begin
            @(posedge aclk);
        end
        if (reg_idx == REG_TRIG_DZ) begin
            trig_dz = value & 32'h3FF;
        end else begin
            stick_dz = value & 32'h3FF;
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Result receiver: stall per idle pattern
    always @(negedge aclk) begin
        m_axis_tready <= ($urandom_range(0, 99) >=
            ((idle_mode == IDLE_RECEIVER) ? 47 : (idle_mode == IDLE_BOTH) ? 27 : 0));
    end

    // Check each result beat against the oldest expectation
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.left_trigger_pct  = m_axis_tdata[6:0];
            got.right_trigger_pct = m_axis_tdata[13:7];
            got.left_x_pct        = m_axis_tdata[21:14];
            got.left_y_pct        = m_axis_tdata[29:22];
            got.right_x_pct       = m_axis_tdata[37:30];
            got.right_y_pct       = m_axis_tdata[45:38];
            got.press_edges       = m_axis_tdata[53:46];
            if (pending_results.size() == 0) begin
                note_error($sformatf("result beat with nothing expected: %h", m_axis_tdata));
            end else begin
                want = pending_results.pop_front();
                compare_field("left_trigger_pct", want.left_trigger_pct,
                              got.left_trigger_pct);
                compare_field("right_trigger_pct", want.right_trigger_pct,
                              got.right_trigger_pct);
                compare_field("left_x_pct", want.left_x_pct, got.left_x_pct);
                compare_field("left_y_pct", want.left_y_pct, got.left_y_pct);
                compare_field("right_x_pct", want.right_x_pct, got.right_x_pct);
                compare_field("right_y_pct", want.right_y_pct, got.right_y_pct);
                compare_field("press_edges", want.press_edges, got.press_edges);
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_gamepad_axis_deadzone_and_button_edges: errors");
            $finish;
        end
    end

    initial begin
        int trig_setting [PHASE_COUNT];
        int stick_setting [PHASE_COUNT];
        trig_setting  = '{20, 0, 1023, 0, 1023, -1, -1, 1};
        stick_setting = '{20, 0, 512, 1023, 0, -1, -1, 511};

        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        error_count   = 0;
        cycle_count   = 0;
        idle_mode     = IDLE_NONE;
        trig_dz       = 20;
        stick_dz      = 20;
        held_dpad     = '0;
        held_face     = '0;

        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed table at the reset deadzones, typed results where obvious
        foreach (DIR_STEPS[i]) begin
            send_report(DIR_STEPS[i].rpt, DIR_STEPS[i].typed, DIR_STEPS[i].res);
        end
        drain();

        // Same table with every trigger scaled and every stick dead
        idle_mode = IDLE_BOTH;
        write_reg(REG_TRIG_DZ, 0);
        write_reg(REG_STICK_DZ, 1023);
        foreach (DIR_STEPS[i]) begin
            send_report(DIR_STEPS[i].rpt, 1'b0, '0);
        end
        drain();

        // Random reports across deadzone settings and idle patterns
        for (int p = 0; p < PHASE_COUNT; p++) begin
            write_reg(REG_TRIG_DZ, (trig_setting[p] < 0) ?
                      $urandom_range(0, 1023) : trig_setting[p]);
            write_reg(REG_STICK_DZ, (stick_setting[p] < 0) ?
                      $urandom_range(0, 600) : stick_setting[p]);
            idle_mode = idle_mode_t'(p % 4);
            repeat (REPORTS_PER_PHASE) begin
                send_report(random_report(), 1'b0, '0);
            end
            drain();
        end

        // Let any stray beat show up before the verdict
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (pending_results.size() != 0) begin
            note_error($sformatf("%0d results never arrived", pending_results.size()));
        end
        if (error_count == 0) begin
            $display("tb_gamepad_axis_deadzone_and_button_edges: clean");
        end else begin
            $display("tb_gamepad_axis_deadzone_and_button_edges: errors");
        end
        $finish;
    end

endmodule
